// File: hdl/tfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_pkg: shared types and constants of the three finger gesture detector
// Field widths, event codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package tfg_pkg;

    // Field widths.
    localparam int TimeW   = 32;
    localparam int CountW  = 3;
    localparam int PosW    = 16;
    localparam int MaskW   = 3;
    localparam int RegW    = 16;
    localparam int IndexW  = 2;
    localparam int EventW  = 2;
    localparam int SumW    = PosW + 2;

    // Result event codes.
    localparam logic [EventW-1:0] EV_NONE  = 2'd0;
    localparam logic [EventW-1:0] EV_UP    = 2'd1;
    localparam logic [EventW-1:0] EV_DOWN  = 2'd2;
    localparam logic [EventW-1:0] EV_CLICK = 2'd3;

    // Command codes.
    localparam logic CMD_FRAME   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Finger count that arms tracking, and the mask of all three fingers.
    localparam logic [CountW-1:0] GESTURE_FINGERS = 3'd3;
    localparam logic [MaskW-1:0]  ALL_STRONG      = 3'b111;

    // Register indexes.
    localparam logic [IndexW-1:0] REG_COOLDOWN  = 2'd0;
    localparam logic [IndexW-1:0] REG_SETTLE    = 2'd1;
    localparam logic [IndexW-1:0] REG_THRESHOLD = 2'd2;
    localparam logic [IndexW-1:0] REG_CLICK     = 2'd3;

    // Register reset values.
    localparam logic [RegW-1:0] COOLDOWN_RESET  = 16'd500;
    localparam logic [RegW-1:0] SETTLE_RESET    = 16'd150;
    localparam logic [RegW-1:0] THRESHOLD_RESET = 16'd30;
    localparam logic [RegW-1:0] CLICK_RESET     = 16'd200;

    typedef logic [EventW-1:0] ev_code_t;

    // One input item.
    typedef struct packed {
        logic              cmd;
        logic [TimeW-1:0]  time_ms;
        logic [CountW-1:0] num_fingers;
        logic [PosW-1:0]   y_first;
        logic [PosW-1:0]   y_second;
        logic [PosW-1:0]   y_third;
        logic [MaskW-1:0]  strong_mask;
    } tfg_item_t;

    // Current configuration.
    typedef struct packed {
        logic [RegW-1:0] cooldown_ms;
        logic [RegW-1:0] settle_ms;
        logic [RegW-1:0] move_threshold;
        logic [RegW-1:0] click_time_ms;
    } tfg_cfg_t;

endpackage

// File: hdl/tfg_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_item_if: input item channel
// Valid/ready channel that carries one touch frame or release event.
// ----------------------------------------------------------------------------
interface tfg_item_if import tfg_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              cmd;
    logic [TimeW-1:0]  time_ms;
    logic [CountW-1:0] num_fingers;
    logic [PosW-1:0]   y_first;
    logic [PosW-1:0]   y_second;
    logic [PosW-1:0]   y_third;
    logic [MaskW-1:0]  strong_mask;

    modport source (
        output valid, cmd, time_ms, num_fingers, y_first, y_second, y_third,
               strong_mask,
        input  ready
    );

    modport sink (
        input  valid, cmd, time_ms, num_fingers, y_first, y_second, y_third,
               strong_mask,
        output ready
    );

endinterface

// File: hdl/tfg_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_result_if: result channel
// Valid/ready channel that carries one detected event code.
// ----------------------------------------------------------------------------
interface tfg_result_if import tfg_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [EventW-1:0] event_res;

    modport source (
        output valid, event_res,
        input  ready
    );

    modport sink (
        input  valid, event_res,
        output ready
    );

endinterface

// File: hdl/tfg_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface tfg_cfg_if import tfg_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [IndexW-1:0] index;
    logic [RegW-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

// File: hdl/tfg_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_cfg_regs: configuration register file
// Holds the four timing and threshold registers, written by index.
// ----------------------------------------------------------------------------
module tfg_cfg_regs import tfg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IndexW-1:0] wr_index,
    input  logic [RegW-1:0]   wr_data,
    output tfg_cfg_t          cfg
);

    tfg_cfg_t cfg_reg;
    tfg_cfg_t cfg_next;

    // Select the register that a write transfer targets.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_COOLDOWN:  cfg_next.cooldown_ms    = wr_data;
                REG_SETTLE:    cfg_next.settle_ms      = wr_data;
                REG_THRESHOLD: cfg_next.move_threshold = wr_data;
                REG_CLICK:     cfg_next.click_time_ms  = wr_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cooldown_ms    <= COOLDOWN_RESET;
            cfg_reg.settle_ms      <= SETTLE_RESET;
            cfg_reg.move_threshold <= THRESHOLD_RESET;
            cfg_reg.click_time_ms  <= CLICK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/tfg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_core: gesture decision logic and tracking state
// Judges one registered item against the tracking state and updates it.
// ----------------------------------------------------------------------------
module tfg_core import tfg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  tfg_item_t item,
    input  tfg_cfg_t  cfg,
    output ev_code_t  ev
);

    logic             armed_reg;
    logic             armed_next;
    logic             fired_reg;
    logic             fired_next;
    logic [TimeW-1:0] arm_time_reg;
    logic [TimeW-1:0] arm_time_next;
    logic [SumW-1:0]  start_y_sum_reg;
    logic [SumW-1:0]  start_y_sum_next;
    logic [TimeW-1:0] last_gesture_time_reg;
    logic [TimeW-1:0] last_gesture_time_next;

    logic [TimeW-1:0] since_gesture;
    logic [TimeW-1:0] since_arm;
    logic [TimeW-1:0] cooldown_ext;
    logic [TimeW-1:0] settle_ext;
    logic [TimeW-1:0] click_ext;
    logic [SumW-1:0]  y_sum;
    logic [SumW-1:0]  limit;
    logic [SumW:0]    sum_hi;
    logic [SumW:0]    start_hi;
    logic             moved_down;
    logic             moved_up;

    // Elapsed times wrap modulo 2^32.
    assign since_gesture = item.time_ms - last_gesture_time_reg;
    assign since_arm     = item.time_ms - arm_time_reg;
    assign cooldown_ext  = {{(TimeW-RegW){1'b0}}, cfg.cooldown_ms};
    assign settle_ext    = {{(TimeW-RegW){1'b0}}, cfg.settle_ms};
    assign click_ext     = {{(TimeW-RegW){1'b0}}, cfg.click_time_ms};

    // Sum of the three Y positions and the movement limit of three thresholds.
    assign y_sum = {2'b00, item.y_first} + {2'b00, item.y_second}
                 + {2'b00, item.y_third};
    assign limit = {1'b0, cfg.move_threshold, 1'b0} + {2'b00, cfg.move_threshold};

    // Movement beyond the limit in either direction, compared without signs.
    assign sum_hi     = {1'b0, y_sum} + {1'b0, limit};
    assign start_hi   = {1'b0, start_y_sum_reg} + {1'b0, limit};
    assign moved_down = {1'b0, y_sum} > start_hi;
    assign moved_up   = {1'b0, start_y_sum_reg} > sum_hi;

    // Decide the event and the next tracking state.
    always_comb
    begin
        ev                     = EV_NONE;
        armed_next             = armed_reg;
        fired_next             = fired_reg;
        arm_time_next          = arm_time_reg;
        start_y_sum_next       = start_y_sum_reg;
        last_gesture_time_next = last_gesture_time_reg;
        if (item.cmd == CMD_FRAME)
        begin
            if (item.num_fingers == GESTURE_FINGERS && since_gesture >= cooldown_ext)
            begin
                if (!armed_reg)
                begin
                    armed_next       = 1'b1;
                    fired_next       = 1'b0;
                    arm_time_next    = item.time_ms;
                    start_y_sum_next = y_sum;
                end
                else if (!fired_reg && since_arm > settle_ext
                         && item.strong_mask == ALL_STRONG
                         && (moved_down || moved_up))
                begin
                    ev                     = moved_down ? EV_DOWN : EV_UP;
                    fired_next             = 1'b1;
                    armed_next             = 1'b0;
                    last_gesture_time_next = item.time_ms;
                end
            end
        end
        else
        begin
            if (armed_reg && !fired_reg && since_arm < click_ext
                && since_gesture > cooldown_ext)
            begin
                ev = EV_CLICK;
            end
            if (armed_reg)
            begin
                armed_next = 1'b0;
                fired_next = 1'b0;
            end
        end
    end

    // Tracking state advances once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg             <= 1'b0;
            fired_reg             <= 1'b0;
            arm_time_reg          <= '0;
            start_y_sum_reg       <= '0;
            last_gesture_time_reg <= '0;
        end
        else if (step)
        begin
            armed_reg             <= armed_next;
            fired_reg             <= fired_next;
            arm_time_reg          <= arm_time_next;
            start_y_sum_reg       <= start_y_sum_next;
            last_gesture_time_reg <= last_gesture_time_next;
        end
    end

endmodule

// File: hdl/three_finger_gesture_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_finger_gesture_detector: three finger swipe and click detector
// Turns touch frames and release events into swipe up, swipe down and
// middle click events.
// ----------------------------------------------------------------------------
// Usage:
// - item carries one touch frame or release event per transfer; result
//   returns exactly one event code for every item, in order (none, swipe
//   up, swipe down, middle click).
// - cfg writes the cooldown, settle, threshold and click time registers by
//   index and is always ready; the user must write it only while the block
//   is idle; the block itself does not enforce this.
// - An accepted item is held in the input register, judged against the
//   tracking state and placed in the result register when it is free.
// - Throughput is one item per cycle while result is not stalled; the single
//   decision stage between the input and result registers sets that figure.
// - When result is stalled, the input register still takes one item, and
//   item.ready drops only while both registers are full.
// - Reset clears the tracking state and both valid flags and loads the
//   register defaults: cooldown 500, settle 150, threshold 30, click 200.
// ----------------------------------------------------------------------------
module three_finger_gesture_detector import tfg_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    tfg_item_if.sink     item,
    tfg_result_if.source result,
    tfg_cfg_if.sink      cfg
);

    tfg_item_t item_reg;
    logic      item_valid_reg;
    logic      item_valid_next;
    ev_code_t  ev_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    logic      item_xfer;
    logic      advance;
    tfg_cfg_t  cfg_now;
    ev_code_t  ev;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    tfg_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_now)
    );

    // Handshake control of the input and result registers.
    assign item_xfer  = item.valid && item.ready;
    assign advance    = item_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            item_reg.cmd          <= item.cmd;
            item_reg.time_ms      <= item.time_ms;
            item_reg.num_fingers  <= item.num_fingers;
            item_reg.y_first      <= item.y_first;
            item_reg.y_second     <= item.y_second;
            item_reg.y_third      <= item.y_third;
            item_reg.strong_mask  <= item.strong_mask;
        end
    end

    // Decision stage.
    tfg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg_now),
        .ev    (ev)
    );

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_reg <= ev;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.event_res = ev_reg;

endmodule

// File: hdl/tfg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfg_checker: port level checks of the gesture detector
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tfg_checker import tfg_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              item_cmd,
    input logic [CountW-1:0] item_num_fingers,
    input logic              result_valid,
    input logic              result_ready,
    input logic [EventW-1:0] result_event_res
);

    logic item_xfer;
    logic out_free;

    assign item_xfer = item_valid && item_ready;
    assign out_free  = !result_valid || result_ready;

    // A stalled result stays offered.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its event code.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_event_res))
        else $error("result event changed while stalled");

    // The block is ready for a new item whenever the receiver is ready for the result.
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("item channel stalled while result channel ready");

    // A frame without three fingers yields no event once the result register is free.
    a_frame_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && item_cmd == CMD_FRAME && item_num_fingers != GESTURE_FINGERS)
        ##1 out_free |=> result_valid && result_event_res == EV_NONE)
        else $error("event from a frame without three fingers");

    // A release never yields a swipe.
    a_release_no_swipe: assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && item_cmd == CMD_RELEASE) ##1 out_free
        |=> result_valid && (result_event_res == EV_NONE || result_event_res == EV_CLICK))
        else $error("swipe from a release");

endmodule

bind three_finger_gesture_detector tfg_checker u_tfg_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .item_cmd          (item.cmd),
    .item_num_fingers  (item.num_fingers),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_event_res  (result.event_res)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the three finger gesture detector
// Drives touch frames and release events through the item channel under
// random source gaps and sink stalls, and predicts each event code with a
// behavioral copy of the tracking state. Every result is compared in order
// with its prediction. A directed pass at the reset settings is followed by
// extreme settings and several random register settings, written through
// the configuration channel while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import tfg_pkg::*;

    localparam int PosMax     = (1 << PosW) - 1;
    localparam int MaxSum     = 3 * PosMax;
    localparam int StallLimit = 1000;

    logic clk = 1'b0;
    logic rst_n;

    tfg_item_if   item_ch ();
    tfg_result_if result_ch ();
    tfg_cfg_if    cfg_ch ();

    three_finger_gesture_detector dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predicted tracking state and registers, updated on each transfer.
    tfg_cfg_t         cfg_model = {COOLDOWN_RESET, SETTLE_RESET, THRESHOLD_RESET, CLICK_RESET};
    logic             trk_armed = 1'b0;
    logic             trk_fired = 1'b0;
    logic [TimeW-1:0] trk_arm_time = '0;
    logic [SumW-1:0]  trk_start_sum = '0;
    logic [TimeW-1:0] trk_last_gesture = '0;

    // Event codes predicted for accepted items and not yet returned.
    ev_code_t pending_events [$];

    // Stimulus side bookkeeping.
    tfg_cfg_t         cfg_now = {COOLDOWN_RESET, SETTLE_RESET, THRESHOLD_RESET, CLICK_RESET};
    logic [TimeW-1:0] clock_ms = '0;
    int               items_sent = 0;
    int               mismatch_count = 0;
    int               stall_cycles = 0;
    bit               no_gaps = 1'b0;

    always #5 clk = ~clk;

    // Works out the event code of one item and advances the tracking state.
    function automatic ev_code_t predict_event(input tfg_item_t it);
        logic [TimeW-1:0] since_arm;
        logic [TimeW-1:0] since_gesture;
        logic [SumW-1:0]  y_sum;
        int               diff;
        int               limit;
        ev_code_t         ev;
        ev = EV_NONE;
        since_arm = it.time_ms - trk_arm_time;
        since_gesture = it.time_ms - trk_last_gesture;
        if (it.cmd == CMD_RELEASE)
        begin
            if (trk_armed && !trk_fired && since_arm < TimeW'(cfg_model.click_time_ms)
                    && since_gesture > TimeW'(cfg_model.cooldown_ms))
                ev = EV_CLICK;
            if (trk_armed)
            begin
                trk_armed = 1'b0;
                trk_fired = 1'b0;
            end
            return ev;
        end
        if (it.num_fingers != GESTURE_FINGERS)
            return EV_NONE;
        if (since_gesture < TimeW'(cfg_model.cooldown_ms))
            return EV_NONE;
        y_sum = SumW'(it.y_first) + SumW'(it.y_second) + SumW'(it.y_third);
        if (!trk_armed)
        begin
            trk_arm_time = it.time_ms;
            trk_armed = 1'b1;
            trk_fired = 1'b0;
            trk_start_sum = y_sum;
            return EV_NONE;
        end
        if (trk_fired)
            return EV_NONE;
        if (since_arm <= TimeW'(cfg_model.settle_ms))
            return EV_NONE;
        if (it.strong_mask != ALL_STRONG)
            return EV_NONE;
        diff = int'(y_sum) - int'(trk_start_sum);
        limit = 3 * int'(cfg_model.move_threshold);
        if (diff > limit || -diff > limit)
        begin
            trk_fired = 1'b1;
            trk_last_gesture = it.time_ms;
            trk_armed = 1'b0;
            ev = (diff > 0) ? EV_DOWN : EV_UP;
        end
        return ev;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Register writes, item predictions, result checks and the stall watchdog.
    always @(posedge clk)
    begin : monitor
        tfg_item_t seen;
        ev_code_t  want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_COOLDOWN:  cfg_model.cooldown_ms = cfg_ch.data;
                    REG_SETTLE:    cfg_model.settle_ms = cfg_ch.data;
                    REG_THRESHOLD: cfg_model.move_threshold = cfg_ch.data;
                    REG_CLICK:     cfg_model.click_time_ms = cfg_ch.data;
                    default: ;
                endcase
            end
            if (item_ch.valid && item_ch.ready)
            begin
                seen.cmd = item_ch.cmd;
                seen.time_ms = item_ch.time_ms;
                seen.num_fingers = item_ch.num_fingers;
                seen.y_first = item_ch.y_first;
                seen.y_second = item_ch.y_second;
                seen.y_third = item_ch.y_third;
                seen.strong_mask = item_ch.strong_mask;
                pending_events.push_back(predict_event(seen));
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_events.size() == 0)
                begin
                    report_mismatch($sformatf("event_res %0d with no item pending",
                                              result_ch.event_res));
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (result_ch.event_res !== want)
                        report_mismatch($sformatf("event_res got %0d, expected %0d",
                                                  result_ch.event_res, want));
                end
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= StallLimit)
            begin
                $display("FAIL three_finger_gesture_detector");
                $finish;
            end
        end
    end

    // Number of idle cycles before a transfer, shared by both sides.
    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Result sink: random stalls before each transfer.
    initial
    begin : result_sink
        int wait_cycles;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            wait_cycles = draw_gap();
            if (wait_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    // Sends one item and returns at the edge of its transfer.
    task automatic send_item(input tfg_item_t it);
        int wait_cycles;
        wait_cycles = draw_gap();
        if (wait_cycles > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd <= it.cmd;
        item_ch.time_ms <= it.time_ms;
        item_ch.num_fingers <= it.num_fingers;
        item_ch.y_first <= it.y_first;
        item_ch.y_second <= it.y_second;
        item_ch.y_third <= it.y_third;
        item_ch.strong_mask <= it.strong_mask;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    // Stops the item stream and waits until every result has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all four registers in one burst; the block must be idle.
    task automatic set_config(input logic [RegW-1:0] cool, input logic [RegW-1:0] settle,
                              input logic [RegW-1:0] thr, input logic [RegW-1:0] click);
        logic [IndexW-1:0] order [4];
        logic [RegW-1:0]   vals [4];
        order = '{REG_COOLDOWN, REG_SETTLE, REG_THRESHOLD, REG_CLICK};
        vals = '{cool, settle, thr, click};
        cfg_now.cooldown_ms = cool;
        cfg_now.settle_ms = settle;
        cfg_now.move_threshold = thr;
        cfg_now.click_time_ms = click;
        cfg_ch.valid <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.index <= order[i];
            cfg_ch.data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic tfg_item_t frame_item(input logic [TimeW-1:0] t,
                                             input logic [CountW-1:0] n,
                                             input logic [PosW-1:0] ya,
                                             input logic [PosW-1:0] yb,
                                             input logic [PosW-1:0] yc,
                                             input logic [MaskW-1:0] mask);
        tfg_item_t it;
        it.cmd = CMD_FRAME;
        it.time_ms = t;
        it.num_fingers = n;
        it.y_first = ya;
        it.y_second = yb;
        it.y_third = yc;
        it.strong_mask = mask;
        return it;
    endfunction

    // A release carries random junk in the fields it does not use.
    function automatic tfg_item_t release_item(input logic [TimeW-1:0] t);
        tfg_item_t it;
        it = frame_item(t, CountW'($urandom), PosW'($urandom), PosW'($urandom),
                        PosW'($urandom), MaskW'($urandom));
        it.cmd = CMD_RELEASE;
        return it;
    endfunction

    function automatic tfg_item_t noise_item();
        tfg_item_t it;
        logic [TimeW-1:0] t;
        t = $urandom_range(0, 1) ? TimeW'($urandom) : clock_ms + $urandom_range(0, 2000);
        it = frame_item(t, CountW'($urandom), PosW'($urandom), PosW'($urandom),
                        PosW'($urandom), MaskW'($urandom));
        it.cmd = $urandom_range(0, 1) ? CMD_RELEASE : CMD_FRAME;
        return it;
    endfunction

    // A time offset close to a boundary, or anywhere up to twice past it.
    function automatic logic [TimeW-1:0] near(input logic [TimeW-1:0] v);
        case ($urandom_range(0, 5))
            0: return v - 1;
            1: return v;
            2: return v + 1;
            default: return $urandom_range(0, 2 * v + 2);
        endcase
    endfunction

    function automatic logic [CountW-1:0] pick_count();
        return ($urandom_range(0, 9) == 0) ? CountW'($urandom) : GESTURE_FINGERS;
    endfunction

    function automatic logic [RegW-1:0] pick_reg();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return RegW'($urandom_range(1, 20));
            default: return RegW'($urandom_range(20, 1000));
        endcase
    endfunction

    // Splits a Y sum into three positions that each fit the field.
    function automatic void split_sum(input int total, output logic [PosW-1:0] ya,
                                      output logic [PosW-1:0] yb, output logic [PosW-1:0] yc);
        int lo;
        int hi;
        int rest;
        lo = (total > 2 * PosMax) ? total - 2 * PosMax : 0;
        hi = (total < PosMax) ? total : PosMax;
        ya = PosW'($urandom_range(lo, hi));
        rest = total - int'(ya);
        lo = (rest > PosMax) ? rest - PosMax : 0;
        hi = (rest < PosMax) ? rest : PosMax;
        yb = PosW'($urandom_range(lo, hi));
        yc = PosW'(rest - int'(yb));
    endfunction

    // Mostly whole gestures with random content: an arming frame, movement
    // frames around the settle time and swipe threshold, then a release
    // around the click time. The rest is unstructured noise.
    task automatic run_random(input int n_items);
        int               target;
        int               start_sum;
        int               goal;
        logic [TimeW-1:0] t0;
        logic [TimeW-1:0] off;
        logic [TimeW-1:0] max_off;
        logic [PosW-1:0]  ya;
        logic [PosW-1:0]  yb;
        logic [PosW-1:0]  yc;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            no_gaps = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_item(noise_item());
                continue;
            end
            t0 = clock_ms + near(TimeW'(cfg_now.cooldown_ms));
            case ($urandom_range(0, 5))
                0: start_sum = 0;
                1: start_sum = MaxSum;
                default: start_sum = $urandom_range(0, MaxSum);
            endcase
            split_sum(start_sum, ya, yb, yc);
            send_item(frame_item(t0, pick_count(), ya, yb, yc, MaskW'($urandom)));
            max_off = '0;
            repeat ($urandom_range(0, 4))
            begin
                off = near(TimeW'(cfg_now.settle_ms));
                goal = int'(near(3 * TimeW'(cfg_now.move_threshold)));
                goal = $urandom_range(0, 1) ? start_sum + goal : start_sum - goal;
                if (goal < 0)
                    goal = 0;
                if (goal > MaxSum)
                    goal = MaxSum;
                split_sum(goal, ya, yb, yc);
                send_item(frame_item(t0 + off, pick_count(), ya, yb, yc,
                                     ($urandom_range(0, 3) != 0) ? ALL_STRONG
                                                                 : MaskW'($urandom)));
                if (off > max_off)
                    max_off = off;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                off = near(TimeW'(cfg_now.click_time_ms));
                send_item(release_item(t0 + off));
                if (off > max_off)
                    max_off = off;
            end
            clock_ms = t0 + max_off;
        end
        no_gaps = 1'b0;
    endtask

    // Reset settings: cooldown, settle and click boundaries, both swipe
    // directions, weak fingers, other finger counts and a wrapping clock.
    task automatic test_reset_defaults();
        send_item(frame_item(32'd0, GESTURE_FINGERS, 16'd100, 16'd100, 16'd100, ALL_STRONG));
        send_item(frame_item(32'd1000, 3'd2, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(frame_item(32'd1000, 3'd4, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(frame_item(32'd1000, 3'd0, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(frame_item(32'd1000, 3'd7, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(release_item(32'd1000));
        // Arm, then movement before settling, at the threshold, and weak.
        send_item(frame_item(32'd1000, GESTURE_FINGERS, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(frame_item(32'd1100, GESTURE_FINGERS, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             ALL_STRONG));
        send_item(frame_item(32'd1151, GESTURE_FINGERS, 16'd30, 16'd30, 16'd30, ALL_STRONG));
        send_item(frame_item(32'd1151, GESTURE_FINGERS, 16'd30, 16'd30, 16'd31, 3'b110));
        send_item(frame_item(32'd1151, GESTURE_FINGERS, 16'd30, 16'd30, 16'd31, ALL_STRONG));
        // Inside the cooldown a frame is dropped and a release does nothing.
        send_item(frame_item(32'd1200, GESTURE_FINGERS, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(release_item(32'd1200));
        // Cooldown exactly over: arm at the top of the range, swipe up.
        send_item(frame_item(32'd1651, GESTURE_FINGERS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000));
        send_item(frame_item(32'd1801, GESTURE_FINGERS, 16'd0, 16'd0, 16'd0, ALL_STRONG));
        send_item(frame_item(32'd1802, GESTURE_FINGERS, 16'hFFFF, 16'hFFFF, 16'd65444,
                             ALL_STRONG));
        // A click needs the cooldown strictly passed and a quick release.
        send_item(frame_item(32'd2302, GESTURE_FINGERS, 16'd5, 16'd5, 16'd5, 3'b000));
        send_item(release_item(32'd2302));
        send_item(frame_item(32'd2303, GESTURE_FINGERS, 16'd5, 16'd5, 16'd5, ALL_STRONG));
        send_item(release_item(32'd2502));
        send_item(frame_item(32'd2600, GESTURE_FINGERS, 16'd5, 16'd5, 16'd5, ALL_STRONG));
        send_item(release_item(32'd2800));
        // The clock wraps between arming and the swipe.
        send_item(frame_item(32'hFFFF_FF80, GESTURE_FINGERS, 16'd1000, 16'd1000, 16'd1000,
                             ALL_STRONG));
        send_item(frame_item(32'h0000_0040, GESTURE_FINGERS, 16'd900, 16'd900, 16'd1000,
                             ALL_STRONG));
        send_item(release_item(32'h0000_0050));
        drain();
    endtask

    // All registers at zero, then all at their maximum.
    task automatic test_extreme_settings();
        logic [TimeW-1:0] t;
        t = 32'h1000_0000;
        set_config('0, '0, '0, '0);
        send_item(frame_item(t, GESTURE_FINGERS, 16'd10, 16'd10, 16'd10, ALL_STRONG));
        send_item(frame_item(t, GESTURE_FINGERS, 16'd10, 16'd10, 16'd11, ALL_STRONG));
        send_item(frame_item(t + 1, GESTURE_FINGERS, 16'd10, 16'd10, 16'd11, ALL_STRONG));
        send_item(frame_item(t + 1, GESTURE_FINGERS, 16'd10, 16'd10, 16'd10, ALL_STRONG));
        send_item(release_item(t + 1));
        clock_ms = t + 2;
        run_random(150);
        drain();
        set_config('1, '1, '1, '1);
        run_random(150);
        drain();
    endtask

    // Several random register settings, each with its own random traffic.
    task automatic test_random_settings();
        repeat (8)
        begin
            set_config(pick_reg(), pick_reg(), pick_reg(), pick_reg());
            clock_ms = $urandom_range(0, 3) == 0 ? TimeW'($urandom) : clock_ms;
            run_random(190);
            drain();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.cmd <= CMD_FRAME;
        item_ch.time_ms <= '0;
        item_ch.num_fingers <= '0;
        item_ch.y_first <= '0;
        item_ch.y_second <= '0;
        item_ch.y_third <= '0;
        item_ch.strong_mask <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_COOLDOWN;
        cfg_ch.data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extreme_settings();
        test_random_settings();
        if (mismatch_count == 0)
            $display("PASS three_finger_gesture_detector");
        else
            $display("FAIL three_finger_gesture_detector");
        $finish;
    end

endmodule
